[rtl/sgw_pkg.sv]
// sgw_pkg: widths, constants, types and helpers of the savgol weight generator
`default_nettype none
package sgw_pkg;

   localparam int MAX_HALF_WIDTH = 16;
   localparam int MAX_ORDER      = 8;
   localparam int FRAC_BITS      = 24;

   localparam int VAL_W     = 48;   // signed q values, magnitude below 2^47
   localparam int ACC_W     = 97;   // accumulator of the shared multiply unit
   localparam int WIDE_W    = 64;   // wide operand of the multiply unit
   localparam int DIG_W     = 16;   // narrow operand (one digit) of the multiply unit
   localparam int DEN_W     = 9;    // divisor width
   localparam int DIV_STEPS = 64;   // one quotient bit per cycle
   localparam int CNT_W     = 6;
   localparam int R_W       = 25;   // falling-factorial ratio, at most 1.0
   localparam int F_W       = 32;   // (2k+1) times ratio
   localparam int IDX_W     = 4;
   localparam int CSR_AW    = 4;

   localparam logic [1:0] REG_HALF_WIDTH  = 2'd0;
   localparam logic [1:0] REG_POLY_ORDER  = 2'd1;
   localparam logic [1:0] REG_DERIV_ORDER = 2'd2;
   localparam logic [1:0] REG_EVAL_OFFSET = 2'd3;

   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic signed [ACC_W-1:0] acc_type;

   typedef struct packed {
      logic [VAL_W-1:0] mag;
      logic             sat;
   } rnd_type;

   localparam val_type VAL_BOUND = 48'sh7FFF_FFFF_FFFF;
   localparam val_type Q_ONE     = 48'sh0000_0100_0000;

   function automatic logic [VAL_W-1:0] abs_val(input val_type v);
      abs_val = v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
   endfunction

   // rounds a non-negative q(2F) product to q(F), clipped to the value bound
   function automatic rnd_type round_clip(input acc_type a);
      logic [ACC_W-1:0] t;
      rnd_type          r;
      t = ($unsigned(a) + (ACC_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (t > ACC_W'(VAL_BOUND)) begin
         r.mag = VAL_W'(VAL_BOUND);
         r.sat = 1'b1;
      end else begin
         r.mag = t[VAL_W-1:0];
         r.sat = 1'b0;
      end
      round_clip = r;
   endfunction

endpackage
`default_nettype wire

[rtl/savgol_weight_generator.sv]
// savgol_weight_generator: top level, sequencer around one multiply unit and a divider
`default_nettype none
// Returns one Savitzky-Golay convolution weight (signed Q8.24, saturated) per
// window position, for the fit set by the four registers. The weight is built
// from the Gram-polynomial recurrence, one order at a time, on a single shared
// 16x64-bit multiply-accumulate unit and a bit-serial divider that yields one
// quotient bit a cycle, so the divisions set the pace. An item that is flagged
// invalid or whose derivative exceeds the order skips the recurrence and goes
// straight to the output stage. The block takes one item at a time; a finished
// result waits in the output register while the next item is taken.
module savgol_weight_generator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [5:0]             req_point_pos,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [31:0]                 rsp_coeff,
   output logic                               rsp_invalid,
   output logic                               rsp_saturated,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [sgw_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import sgw_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_RLOAD  = 4'd1;
   localparam logic [3:0] ST_DSTART = 4'd2;
   localparam logic [3:0] ST_DIV    = 4'd3;
   localparam logic [3:0] ST_DEND   = 4'd4;
   localparam logic [3:0] ST_G1     = 4'd5;
   localparam logic [3:0] ST_G2     = 4'd6;
   localparam logic [3:0] ST_G3     = 4'd7;
   localparam logic [3:0] ST_G4     = 4'd8;
   localparam logic [3:0] ST_T1     = 4'd9;
   localparam logic [3:0] ST_T2     = 4'd10;
   localparam logic [3:0] ST_T3     = 4'd11;
   localparam logic [3:0] ST_T4     = 4'd12;
   localparam logic [3:0] ST_T5     = 4'd13;
   localparam logic [3:0] ST_FIN    = 4'd14;

   localparam logic DST_R    = 1'b0;
   localparam logic DST_GRAM = 1'b1;

   // configuration
   logic [4:0]        hw_ff;
   logic [3:0]        po_ff;
   logic [3:0]        do_ff;
   logic [5:0]        eo_ff;

   logic [3:0]        state_ff;
   logic signed [5:0] xp_ff, xt_ff;
   logic [4:0]        m_ff;
   logic [3:0]        n_ff, s_ff, k_ff;
   logic [IDX_W-1:0]  d_ff;
   logic              gsel_ff;
   logic [1:0]        j_ff;
   val_type           prev_p_ff, older_p_ff, lower_ff, term_ff, sum_ff, gt_ff;
   val_type           prev_t_ff [0:MAX_ORDER];
   val_type           older_t_ff [0:MAX_ORDER];
   acc_type           acc_ff;
   logic [WIDE_W-1:0] dq_ff;
   logic [DEN_W-1:0]  rem_ff, den_ff;
   logic              dneg_ff, dst_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [R_W-1:0]    r_ff;
   logic [F_W-1:0]    f_ff;
   logic              sat_ff, inv_ff;
   logic              rsp_valid_ff, rinv_ff, rsat_ff;
   logic signed [31:0] coeff_ff;

   // accept-time limits
   logic [4:0] m_clip;
   logic [3:0] n_clip;
   logic       bad_order;
   assign m_clip    = (hw_ff > 5'(MAX_HALF_WIDTH)) ? 5'(MAX_HALF_WIDTH) : hw_ff;
   assign n_clip    = (po_ff > 4'(MAX_ORDER)) ? 4'(MAX_ORDER) : po_ff;
   assign bad_order = {2'b00, n_clip} > {m_clip, 1'b0};

   // recurrence coefficients for the current order
   logic [6:0]  two_m, c_2mk, c_2mk1m, c_4k2;
   logic [3:0]  c_km1;
   logic [10:0] ca_full, dg_full;
   logic [6:0]  r_den;
   assign two_m   = {1'b0, m_ff, 1'b0};
   assign c_2mk   = two_m + {3'b000, k_ff};
   assign c_2mk1m = two_m - {3'b000, k_ff} + 7'd1;
   assign c_4k2   = {1'b0, k_ff, 2'b00} - 7'd2;
   assign c_km1   = k_ff - 4'd1;
   assign ca_full = c_km1 * c_2mk;
   assign dg_full = k_ff * c_2mk1m;
   assign r_den   = (k_ff == 4'd0) ? (two_m + 7'd1) : (c_2mk + 7'd1);

   // operands of the gram step in hand
   logic signed [5:0] cur_x;
   logic [5:0]        cur_x_mag;
   val_type           cur_prev, cur_older;
   assign cur_x     = gsel_ff ? xt_ff : xp_ff;
   assign cur_x_mag = cur_x[5] ? 6'(-cur_x) : 6'(cur_x);
   assign cur_prev  = gsel_ff ? prev_t_ff[d_ff] : prev_p_ff;
   assign cur_older = gsel_ff ? older_t_ff[d_ff] : older_p_ff;

   logic [ACC_W-1:0] acc_mag;
   logic [VAL_W-1:0] gt_mag;
   assign acc_mag = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign gt_mag  = abs_val(gt_ff);

   // shared multiply-accumulate unit
   logic              mclr, mneg;
   logic [1:0]        msh;
   logic [DIG_W-1:0]  mdig;
   logic [WIDE_W-1:0] mwide;
   logic [DIG_W+WIDE_W-1:0] mprod;
   logic [ACC_W-1:0]  mshift;
   acc_type           acc_in;

   always_comb begin
      mclr  = 1'b0;
      mneg  = 1'b0;
      msh   = 2'd0;
      mdig  = '0;
      mwide = '0;
      case (state_ff)
         ST_RLOAD: begin
            mclr  = 1'b1;
            mdig  = (k_ff == 4'd0) ? DIG_W'(1) : DIG_W'(c_2mk1m);
            mwide = (k_ff == 4'd0) ? WIDE_W'(Q_ONE) : WIDE_W'(r_ff);
         end
         ST_G1: begin
            mclr  = 1'b1;
            mdig  = DIG_W'(cur_x_mag);
            mwide = WIDE_W'(abs_val(cur_prev));
            mneg  = cur_x[5] ^ cur_prev[VAL_W-1];
         end
         ST_G2: begin
            mdig  = DIG_W'(d_ff);
            mwide = WIDE_W'(abs_val(lower_ff));
            mneg  = lower_ff[VAL_W-1];
         end
         ST_G3: begin
            mclr  = 1'b1;
            mdig  = DIG_W'(c_4k2);
            mwide = acc_mag[WIDE_W-1:0];
            mneg  = acc_ff[ACC_W-1];
         end
         ST_G4: begin
            // subtract the older term
            mdig  = DIG_W'(ca_full);
            mwide = WIDE_W'(abs_val(cur_older));
            mneg  = ~cur_older[VAL_W-1];
         end
         ST_T1: begin
            mclr  = (j_ff == 2'd0);
            msh   = j_ff;
            mdig  = gt_mag[DIG_W*j_ff +: DIG_W];
            mwide = WIDE_W'(abs_val(prev_p_ff));
         end
         ST_T2: begin
            mclr  = 1'b1;
            mdig  = DIG_W'({k_ff, 1'b1});
            mwide = WIDE_W'(r_ff);
         end
         ST_T4: begin
            mclr  = (j_ff == 2'd0);
            msh   = j_ff;
            mdig  = f_ff[DIG_W*j_ff[0] +: DIG_W];
            mwide = WIDE_W'(abs_val(term_ff));
         end
         default: begin
            mclr  = 1'b0;
         end
      endcase
   end

   assign mprod  = mdig * mwide;
   assign mshift = ACC_W'(mprod) << {msh, 4'b0000};
   assign acc_in = (mclr ? acc_type'(0) : acc_ff)
                   + (mneg ? acc_type'(-mshift) : acc_type'(mshift));

   // divider: rounding offset added up front, then one quotient bit a cycle
   logic [DEN_W-1:0]  den_sel;
   logic [WIDE_W-1:0] dvd_start;
   logic [DEN_W:0]    rem_t;
   logic              rem_ge;
   assign den_sel   = (dst_ff == DST_R) ? DEN_W'(r_den) : dg_full[DEN_W-1:0];
   assign dvd_start = acc_mag[WIDE_W-1:0] + WIDE_W'(den_sel >> 1);
   assign rem_t     = {rem_ff, dq_ff[WIDE_W-1]};
   assign rem_ge    = rem_t >= {1'b0, den_ff};

   // signed, clipped quotient of a gram step
   logic              q_sat;
   logic [VAL_W-1:0]  q_mag;
   val_type           q_val;
   assign q_sat = dq_ff > WIDE_W'(VAL_BOUND);
   assign q_mag = q_sat ? VAL_W'(VAL_BOUND) : dq_ff[VAL_W-1:0];
   assign q_val = dneg_ff ? val_type'(-q_mag) : val_type'(q_mag);

   // rounding of products and the running sum
   rnd_type            rnd;
   val_type            rnd_val;
   logic signed [VAL_W:0] sum_wide;
   logic               sum_sat;
   val_type            sum_in;
   assign rnd      = round_clip(acc_ff);
   assign rnd_val  = ((state_ff == ST_T2) ? (prev_p_ff[VAL_W-1] ^ gt_ff[VAL_W-1])
                                          : term_ff[VAL_W-1])
                     ? val_type'(-rnd.mag) : val_type'(rnd.mag);
   assign sum_wide = {sum_ff[VAL_W-1], sum_ff} + {rnd_val[VAL_W-1], rnd_val};
   assign sum_sat  = (sum_wide > (VAL_W+1)'(VAL_BOUND)) || (sum_wide < -(VAL_W+1)'(VAL_BOUND));
   assign sum_in   = (sum_wide > (VAL_W+1)'(VAL_BOUND)) ? VAL_BOUND :
                     (sum_wide < -(VAL_W+1)'(VAL_BOUND)) ? val_type'(-VAL_BOUND) :
                     sum_wide[VAL_W-1:0];

   // final Q8.24 clip
   logic               out_hi, out_lo;
   logic signed [31:0] coeff_in;
   assign out_hi   = sum_ff > val_type'(48'sh0000_7FFF_FFFF);
   assign out_lo   = sum_ff < val_type'(-48'sh0000_8000_0000);
   assign coeff_in = out_hi ? 32'sh7FFF_FFFF : out_lo ? 32'sh8000_0000 : sum_ff[31:0];

   logic req_fire, csr_wr;
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_paddr[3:2])
         REG_HALF_WIDTH:  csr_prdata = 32'(hw_ff);
         REG_POLY_ORDER:  csr_prdata = 32'(po_ff);
         REG_DERIV_ORDER: csr_prdata = 32'(do_ff);
         REG_EVAL_OFFSET: csr_prdata = 32'(eo_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff        <= 5'd3;
         po_ff        <= 4'd4;
         do_ff        <= 4'd0;
         eo_ff        <= 6'd0;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            case (csr_paddr[3:2])
               REG_HALF_WIDTH:  hw_ff <= csr_pwdata[4:0];
               REG_POLY_ORDER:  po_ff <= csr_pwdata[3:0];
               REG_DERIV_ORDER: do_ff <= csr_pwdata[3:0];
               REG_EVAL_OFFSET: eo_ff <= csr_pwdata[5:0];
               default:         hw_ff <= hw_ff;
            endcase
         end
         // a result finishing now takes the output register over
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  xp_ff      <= req_point_pos;
                  xt_ff      <= eo_ff;
                  m_ff       <= m_clip;
                  n_ff       <= n_clip;
                  s_ff       <= do_ff;
                  k_ff       <= 4'd0;
                  sum_ff     <= '0;
                  sat_ff     <= 1'b0;
                  inv_ff     <= bad_order;
                  prev_p_ff  <= Q_ONE;
                  older_p_ff <= '0;
                  gt_ff      <= (do_ff == 4'd0) ? Q_ONE : val_type'(0);
                  for (int i = 0; i <= MAX_ORDER; i++) begin
                     older_t_ff[i] <= '0;
                     prev_t_ff[i]  <= (i == 0) ? Q_ONE : val_type'(0);
                  end
                  if (bad_order || (do_ff > n_clip)) begin
                     state_ff <= ST_FIN;
                  end else begin
                     state_ff <= ST_RLOAD;
                  end
               end
            end
            ST_RLOAD: begin
               acc_ff   <= acc_in;
               dst_ff   <= DST_R;
               state_ff <= ST_DSTART;
            end
            ST_DSTART: begin
               den_ff   <= den_sel;
               dq_ff    <= dvd_start;
               rem_ff   <= '0;
               dneg_ff  <= acc_ff[ACC_W-1];
               cnt_ff   <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               rem_ff <= rem_ge ? DEN_W'(rem_t - {1'b0, den_ff}) : rem_t[DEN_W-1:0];
               dq_ff  <= {dq_ff[WIDE_W-2:0], rem_ge};
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
                  state_ff <= ST_DEND;
               end
            end
            ST_DEND: begin
               if (dst_ff == DST_R) begin
                  r_ff     <= dq_ff[R_W-1:0];
                  j_ff     <= 2'd0;
                  state_ff <= ST_T1;
               end else begin
                  sat_ff <= sat_ff | q_sat;
                  if (!gsel_ff) begin
                     older_p_ff <= prev_p_ff;
                     prev_p_ff  <= q_val;
                     gsel_ff    <= 1'b1;
                     d_ff       <= '0;
                     lower_ff   <= '0;
                     state_ff   <= ST_G1;
                  end else begin
                     // old value feeds the next derivative as its lower term
                     older_t_ff[d_ff] <= prev_t_ff[d_ff];
                     prev_t_ff[d_ff]  <= q_val;
                     lower_ff         <= prev_t_ff[d_ff];
                     if (d_ff == IDX_W'(s_ff)) begin
                        gt_ff    <= q_val;
                        state_ff <= ST_RLOAD;
                     end else begin
                        d_ff     <= d_ff + IDX_W'(1);
                        state_ff <= ST_G1;
                     end
                  end
               end
            end
            ST_G1: begin
               acc_ff   <= acc_in;
               state_ff <= ST_G2;
            end
            ST_G2: begin
               acc_ff   <= acc_in;
               state_ff <= ST_G3;
            end
            ST_G3: begin
               acc_ff   <= acc_in;
               state_ff <= ST_G4;
            end
            ST_G4: begin
               acc_ff   <= acc_in;
               dst_ff   <= DST_GRAM;
               state_ff <= ST_DSTART;
            end
            ST_T1: begin
               acc_ff <= acc_in;
               j_ff   <= j_ff + 2'd1;
               if (j_ff == 2'd2) begin
                  state_ff <= ST_T2;
               end
            end
            ST_T2: begin
               term_ff  <= rnd_val;
               sat_ff   <= sat_ff | rnd.sat;
               acc_ff   <= acc_in;
               state_ff <= ST_T3;
            end
            ST_T3: begin
               f_ff     <= acc_ff[F_W-1:0];
               j_ff     <= 2'd0;
               state_ff <= ST_T4;
            end
            ST_T4: begin
               acc_ff <= acc_in;
               j_ff   <= j_ff + 2'd1;
               if (j_ff == 2'd1) begin
                  state_ff <= ST_T5;
               end
            end
            ST_T5: begin
               sum_ff <= sum_in;
               sat_ff <= sat_ff | rnd.sat | sum_sat;
               if (k_ff == n_ff) begin
                  state_ff <= ST_FIN;
               end else begin
                  k_ff     <= k_ff + 4'd1;
                  gsel_ff  <= 1'b0;
                  d_ff     <= '0;
                  state_ff <= ST_G1;
               end
            end
            ST_FIN: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  coeff_ff     <= coeff_in;
                  rinv_ff      <= inv_ff;
                  rsat_ff      <= sat_ff | out_hi | out_lo;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_coeff     = coeff_ff;
   assign rsp_invalid   = rinv_ff;
   assign rsp_saturated = rsat_ff;

endmodule
`default_nettype wire
